// ----- design/assert_macros.svh -----
// Assertion helpers used by the checker.
// Both expect i_clk and i_rst_n in scope; checks are off while reset is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define AST_SAME(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define AST_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle check");

`endif

// ----- design/ps2mc_pkg.sv -----
package ps2mc_pkg;

    // cursor position register width
    localparam int CoordW  = 12;
    localparam int SumW    = 18;   // holds any position plus any motion, signed
    localparam int ScreenW = 12;
    localparam int CursorW = 12;
    localparam int BtnW    = 3;

    localparam logic [7:0] AckByte  = 8'hFA;
    localparam int         XSignBit = 4;
    localparam int         YSignBit = 5;

    localparam logic [CoordW-1:0] CoordMax   = '1;
    localparam logic [CoordW-1:0] ResetPosX  = CoordW'(160);
    localparam logic [CoordW-1:0] ResetPosY  = CoordW'(100);
    localparam logic [ScreenW-1:0] ResetScrW = ScreenW'(320);
    localparam logic [ScreenW-1:0] ResetScrH = ScreenW'(200);

    // configuration register indexes
    localparam logic RegScreenW = 1'b0;
    localparam logic RegScreenH = 1'b1;

    typedef logic [CoordW-1:0] t_coord;

    // byte position within the stream
    typedef enum logic [1:0] {
        PH_WAIT_ACK = 2'd0,
        PH_STATUS   = 2'd1,
        PH_X        = 2'd2,
        PH_Y        = 2'd3
    } t_phase;

    // add motion to a position, clamp to 0..min(screen, CoordMax)
    function automatic t_coord clamp_axis(input t_coord pos,
                                          input logic signed [9:0] delta,
                                          input logic [ScreenW-1:0] screen);
        logic [SumW-1:0]        lim;
        logic signed [SumW-1:0] v;
        lim = (SumW'(screen) < SumW'(CoordMax)) ? SumW'(screen) : SumW'(CoordMax);
        v   = signed'(SumW'(pos)) + SumW'(delta);
        if (v <= 0) begin
            return '0;
        end else if (v > signed'(lim)) begin
            return CoordW'(lim);
        end else begin
            return CoordW'(v);
        end
    endfunction

endpackage

// ----- design/ps2_mouse_packet_cursor.sv -----
// PS/2 mouse packet decoder with cursor tracking.
// Input channel: one raw mouse byte per request (i_in_valid / o_in_stall).
// Bytes are dropped until the 0xFA acknowledge; after that every three bytes
// (status, X, Y) form a packet and produce one result request on the output
// channel (o_out_valid / i_out_stall): buttons, X motion, negated Y motion
// and the new cursor position clamped to 0..screen size per axis.
// Screen sizes are set through the write port (index 0 width, 1 height)
// and may only change while no packet is in flight.
// Latency: the result is valid the cycle after the third packet byte is taken.
// Throughput: one byte per cycle unless a stalled result is pending; all decode
// and clamp work is one pass of logic into the output register.
// Reset: screen 320x200, cursor at (160,100), waiting for acknowledge,
// output empty.
// Stall: a pending result holds while i_out_stall is high; input is then
// stalled too, and taken again in the same cycle the result leaves.
module ps2_mouse_packet_cursor (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_mouse_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_buttons,
    output logic signed [8:0] o_move_x,
    output logic signed [9:0] o_move_y,
    output logic [11:0] o_cursor_x,
    output logic [11:0] o_cursor_y
);

    ps2mc_pkg::t_phase r_phase, n_phase;
    logic [7:0]        r_status, n_status;
    logic [7:0]        r_xbyte, n_xbyte;
    ps2mc_pkg::t_coord r_pos_x, n_pos_x;
    ps2mc_pkg::t_coord r_pos_y, n_pos_y;
    logic [ps2mc_pkg::ScreenW-1:0] r_screen_w, r_screen_h;

    logic        r_out_valid, n_out_valid;
    logic [2:0]  r_buttons;
    logic signed [8:0] r_move_x;
    logic signed [9:0] r_move_y;
    logic [11:0] r_cursor_x, r_cursor_y;

    logic              in_take;
    logic              emit;
    logic signed [8:0] dx;
    logic signed [8:0] dy_raw;
    logic signed [9:0] dy;

    // input taken whenever the output register is free or draining
    assign o_in_stall = r_out_valid & i_out_stall;
    assign in_take    = i_in_valid & ~o_in_stall;

    // sign-extended motion from the status sign bits
    assign dx     = signed'({r_status[ps2mc_pkg::XSignBit], r_xbyte});
    assign dy_raw = signed'({r_status[ps2mc_pkg::YSignBit], i_mouse_byte});
    assign dy     = -(10'(dy_raw));

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= ps2mc_pkg::ResetScrW;
            r_screen_h <= ps2mc_pkg::ResetScrH;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ps2mc_pkg::RegScreenW: r_screen_w <= i_cfg_data;
                ps2mc_pkg::RegScreenH: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // byte sequencing and cursor update
    always_comb begin
        n_phase  = r_phase;
        n_status = r_status;
        n_xbyte  = r_xbyte;
        n_pos_x  = r_pos_x;
        n_pos_y  = r_pos_y;
        emit     = 1'b0;
        if (in_take) begin
            case (r_phase)
                ps2mc_pkg::PH_WAIT_ACK: begin
                    if (i_mouse_byte == ps2mc_pkg::AckByte) begin
                        n_phase = ps2mc_pkg::PH_STATUS;
                    end
                end
                ps2mc_pkg::PH_STATUS: begin
                    n_status = i_mouse_byte;
                    n_phase  = ps2mc_pkg::PH_X;
                end
                ps2mc_pkg::PH_X: begin
                    n_xbyte = i_mouse_byte;
                    n_phase = ps2mc_pkg::PH_Y;
                end
                ps2mc_pkg::PH_Y: begin
                    emit    = 1'b1;
                    n_phase = ps2mc_pkg::PH_STATUS;
                    n_pos_x = ps2mc_pkg::clamp_axis(r_pos_x, 10'(dx), r_screen_w);
                    n_pos_y = ps2mc_pkg::clamp_axis(r_pos_y, dy, r_screen_h);
                end
                default: begin
                    n_phase = ps2mc_pkg::PH_WAIT_ACK;
                end
            endcase
        end
        n_out_valid = emit | (r_out_valid & i_out_stall);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ps2mc_pkg::PH_WAIT_ACK;
            r_pos_x     <= ps2mc_pkg::ResetPosX;
            r_pos_y     <= ps2mc_pkg::ResetPosY;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_pos_x     <= n_pos_x;
            r_pos_y     <= n_pos_y;
            r_out_valid <= n_out_valid;
        end
    end

    // packet bytes and result payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status <= '0;
            r_xbyte  <= '0;
        end else begin
            r_status <= n_status;
            r_xbyte  <= n_xbyte;
        end
        if (emit) begin
            r_buttons  <= r_status[ps2mc_pkg::BtnW-1:0];
            r_move_x   <= dx;
            r_move_y   <= dy;
            r_cursor_x <= ps2mc_pkg::CursorW'(n_pos_x);
            r_cursor_y <= ps2mc_pkg::CursorW'(n_pos_y);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_buttons   = r_buttons;
    assign o_move_x    = r_move_x;
    assign o_move_y    = r_move_y;
    assign o_cursor_x  = r_cursor_x;
    assign o_cursor_y  = r_cursor_y;

endmodule

// ----- design/ps2mc_checker.sv -----
`include "assert_macros.svh"

module ps2mc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_we,
    input logic        i_cfg_index,
    input logic [11:0] i_cfg_data,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [7:0]  i_mouse_byte,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [2:0]  o_buttons,
    input logic signed [8:0] o_move_x,
    input logic signed [9:0] o_move_y,
    input logic [11:0] o_cursor_x,
    input logic [11:0] o_cursor_y
);

    logic [11:0] r_scr_w;
    logic [11:0] r_scr_h;
    logic        in_take;

    assign in_take = i_in_valid & ~o_in_stall;

    // shadow of the screen size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_w <= ps2mc_pkg::ResetScrW;
            r_scr_h <= ps2mc_pkg::ResetScrH;
        end else if (i_cfg_we) begin
            if (i_cfg_index == ps2mc_pkg::RegScreenW) begin
                r_scr_w <= i_cfg_data;
            end else begin
                r_scr_h <= i_cfg_data;
            end
        end
    end

    // a stalled result holds
    `AST_NEXT(a_out_hold, o_out_valid && i_out_stall,
        o_out_valid && $stable({o_buttons, o_move_x, o_move_y, o_cursor_x, o_cursor_y}))
    // input only backs up behind a pending result
    `AST_SAME(a_stall_cause, o_in_stall, o_out_valid)
    // a new result comes from a byte taken in the previous cycle
    `AST_SAME(a_result_src, $rose(o_out_valid), $past(in_take))
    // cursor never leaves the screen
    `AST_SAME(a_cursor_bound, o_out_valid, o_cursor_x <= r_scr_w && o_cursor_y <= r_scr_h)

endmodule

bind ps2_mouse_packet_cursor ps2mc_checker u_ps2mc_checker (.*);

// ----- dv/tb_ps2_mouse_packet_cursor.sv -----
module tb_ps2_mouse_packet_cursor;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CycleLimit = 200000;
    localparam int PhaseBytes = 80;

    // one decoded packet as it leaves the block
    typedef struct packed {
        logic [ps2mc_pkg::BtnW-1:0]    buttons;
        logic signed [8:0]             move_x;
        logic signed [9:0]             move_y;
        logic [ps2mc_pkg::CursorW-1:0] cursor_x;
        logic [ps2mc_pkg::CursorW-1:0] cursor_y;
    } t_motion;

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic                          i_cfg_index  = ps2mc_pkg::RegScreenW;
    logic [ps2mc_pkg::ScreenW-1:0] i_cfg_data   = '0;
    logic                          i_in_valid   = 1'b0;
    logic [7:0]                    i_mouse_byte = '0;
    logic                          i_out_stall  = 1'b0;
    logic                          o_in_stall;
    logic                          o_out_valid;
    logic [2:0]                    o_buttons;
    logic signed [8:0]             o_move_x;
    logic signed [9:0]             o_move_y;
    logic [11:0]                   o_cursor_x;
    logic [11:0]                   o_cursor_y;

    // stimulus and expected packets
    logic [7:0] byte_q[$];
    t_motion    motion_q[$];

    // tracked copy of the decoder state and screen size
    ps2mc_pkg::t_phase             trk_phase  = ps2mc_pkg::PH_WAIT_ACK;
    logic [7:0]                    trk_status = '0;
    logic [7:0]                    trk_x      = '0;
    ps2mc_pkg::t_coord             trk_px     = ps2mc_pkg::ResetPosX;
    ps2mc_pkg::t_coord             trk_py     = ps2mc_pkg::ResetPosY;
    logic [ps2mc_pkg::ScreenW-1:0] scr_w      = ps2mc_pkg::ResetScrW;
    logic [ps2mc_pkg::ScreenW-1:0] scr_h      = ps2mc_pkg::ResetScrH;

    bit in_taken = 1'b0;
    int idle_pct = 10;
    int errors   = 0;
    int cycles   = 0;

    ps2_mouse_packet_cursor u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_mouse_byte (i_mouse_byte),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_buttons    (o_buttons),
        .o_move_x     (o_move_x),
        .o_move_y     (o_move_y),
        .o_cursor_x   (o_cursor_x),
        .o_cursor_y   (o_cursor_y)
    );

    always #5 i_clk = ~i_clk;

    // cursor axis update: add motion, hold within 0..screen
    function automatic ps2mc_pkg::t_coord step_axis(input ps2mc_pkg::t_coord pos,
                                                    input int delta,
                                                    input logic [ps2mc_pkg::ScreenW-1:0] screen);
        int lim;
        int v;
        lim = (int'(screen) < int'(ps2mc_pkg::CoordMax)) ? int'(screen)
                                                         : int'(ps2mc_pkg::CoordMax);
        v   = int'(pos) + delta;
        if (v <= 0) begin
            return '0;
        end
        if (v > lim) begin
            return ps2mc_pkg::t_coord'(lim);
        end
        return ps2mc_pkg::t_coord'(v);
    endfunction

    // advance the tracked decoder by one mouse byte
    function automatic void track_byte(input logic [7:0] b);
        t_motion m;
        int      dx;
        int      dy;
        case (trk_phase)
            ps2mc_pkg::PH_WAIT_ACK: begin
                if (b == ps2mc_pkg::AckByte) begin
                    trk_phase = ps2mc_pkg::PH_STATUS;
                end
            end
            ps2mc_pkg::PH_STATUS: begin
                trk_status = b;
                trk_phase  = ps2mc_pkg::PH_X;
            end
            ps2mc_pkg::PH_X: begin
                trk_x     = b;
                trk_phase = ps2mc_pkg::PH_Y;
            end
            default: begin
                dx = int'(trk_x) - (trk_status[ps2mc_pkg::XSignBit] ? 256 : 0);
                // y is negated so that down is positive
                dy = (trk_status[ps2mc_pkg::YSignBit] ? 256 : 0) - int'(b);
                trk_px = step_axis(trk_px, dx, scr_w);
                trk_py = step_axis(trk_py, dy, scr_h);
                m.buttons  = trk_status[ps2mc_pkg::BtnW-1:0];
                m.move_x   = 9'(dx);
                m.move_y   = 10'(dy);
                m.cursor_x = ps2mc_pkg::CursorW'(trk_px);
                m.cursor_y = ps2mc_pkg::CursorW'(trk_py);
                motion_q.push_back(m);
                trk_phase = ps2mc_pkg::PH_STATUS;
            end
        endcase
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, want %0d at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // monitor: check results, track accepted requests and register writes
    always @(posedge i_clk) begin : mon
        t_motion want;
        in_taken = i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (motion_q.size() == 0) begin
                    flag_mismatch("result with none pending", 1, 0);
                end else begin
                    want = motion_q.pop_front();
                    if (o_buttons !== want.buttons)
                        flag_mismatch("buttons", o_buttons, want.buttons);
                    if (o_move_x !== want.move_x)
                        flag_mismatch("move_x", o_move_x, want.move_x);
                    if (o_move_y !== want.move_y)
                        flag_mismatch("move_y", o_move_y, want.move_y);
                    if (o_cursor_x !== want.cursor_x)
                        flag_mismatch("cursor_x", o_cursor_x, want.cursor_x);
                    if (o_cursor_y !== want.cursor_y)
                        flag_mismatch("cursor_y", o_cursor_y, want.cursor_y);
                end
            end
            if (in_taken) begin
                track_byte(i_mouse_byte);
            end
            if (i_cfg_we) begin
                if (i_cfg_index == ps2mc_pkg::RegScreenW) begin
                    scr_w = i_cfg_data;
                end else begin
                    scr_h = i_cfg_data;
                end
            end
        end
    end

    // driver: byte requests from the queue, random gaps and output stalls
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_in_valid || in_taken)) begin
            if (byte_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                i_in_valid   <= 1'b1;
                i_mouse_byte <= byte_q.pop_front();
            end else begin
                i_in_valid <= 1'b0;
            end
        end
        i_out_stall <= i_rst_n && ($urandom_range(99) < idle_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("Verification failed");
            $finish;
        end
    end

    // wait until every byte is taken and every packet has come out
    task automatic drain();
        do begin
            @(posedge i_clk);
            #1;
        end while (byte_q.size() != 0 || (i_in_valid && !in_taken) || motion_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_screen(input logic [ps2mc_pkg::ScreenW-1:0] w,
                                input logic [ps2mc_pkg::ScreenW-1:0] h);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= ps2mc_pkg::RegScreenW;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= ps2mc_pkg::RegScreenH;
        i_cfg_data  <= h;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly whole packets with a drifting direction, some stray bytes
    task automatic queue_random(input int n_bytes);
        logic [7:0] st;
        logic       xs;
        logic       ys;
        int         remaining;
        int         pk;
        remaining = n_bytes;
        pk        = 0;
        xs        = 1'b0;
        ys        = 1'b0;
        while (remaining > 0) begin
            if (pk % 16 == 0) begin
                xs = 1'($urandom_range(1));
                ys = 1'($urandom_range(1));
            end
            pk++;
            if ($urandom_range(9) == 0) begin
                // stray byte shifts the packet framing
                byte_q.push_back(8'($urandom));
                remaining--;
            end else begin
                st = 8'($urandom);
                if ($urandom_range(4) != 0) begin
                    st[ps2mc_pkg::XSignBit] = xs;
                    st[ps2mc_pkg::YSignBit] = ys;
                end
                byte_q.push_back(st);
                byte_q.push_back(8'($urandom));
                byte_q.push_back(8'($urandom));
                remaining -= 3;
            end
        end
    endtask

    initial begin : stim
        int                            ph;
        logic [ps2mc_pkg::ScreenW-1:0] w;
        logic [ps2mc_pkg::ScreenW-1:0] h;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: default 320x200 screen, cursor starts at 160,100
        byte_q = {
            8'h00, 8'hFF, 8'h09, 8'h38,   // ignored until acknowledge
            ps2mc_pkg::AckByte,
            8'h08, 8'h00, 8'h00,          // no motion
            8'h0F, 8'h7F, 8'h01,          // all buttons, +127 x, up 1
            8'h18, 8'hFF, 8'h01,          // x -1
            8'h38, 8'h00, 8'h00,          // x -256, y down 256: y clamps
            8'h08, 8'hFF, 8'hFF,          // x +255, y up 255
            8'h08, 8'hFF, 8'hFF,          // x clamps at width, y at 0
            // acknowledge taken as packet data
            ps2mc_pkg::AckByte, ps2mc_pkg::AckByte, ps2mc_pkg::AckByte
        };
        drain();

        for (ph = 0; ph < 6; ph++) begin
            idle_pct = 10;
            case (ph)
                0: begin
                    w = 12'hFFF;
                    h = 12'hFFF;
                end
                1: begin
                    w = '0;
                    h = '0;
                end
                2: begin
                    w = 12'd1;
                    h = 12'hFFF;
                end
                3: begin
                    // a stretch with no gaps or stalls
                    w = 12'hFFF;
                    h = 12'd1;
                    idle_pct = 0;
                end
                4: begin
                    w = 12'($urandom_range(1, 4095));
                    h = 12'($urandom_range(1, 4095));
                end
                default: begin
                    w = ps2mc_pkg::ResetScrW;
                    h = ps2mc_pkg::ResetScrH;
                end
            endcase
            write_screen(w, h);
            queue_random(PhaseBytes);
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
